// ----- rtl/i2ck_pkg.sv -----
`default_nettype none
package i2ck_pkg;

  // Sequencer phases. Each bus step of the register read has its own phase.
  typedef enum logic [4:0] {
    PH_IDLE = 5'd0,
    PH_S1A  = 5'd1,
    PH_S2A  = 5'd2,
    PH_TXA  = 5'd3,
    PH_K1A  = 5'd4,
    PH_K2A  = 5'd5,
    PH_KPA  = 5'd6,
    PH_TXR  = 5'd7,
    PH_K1R  = 5'd8,
    PH_K2R  = 5'd9,
    PH_KPR  = 5'd10,
    PH_S1B  = 5'd11,
    PH_S2B  = 5'd12,
    PH_TXD  = 5'd13,
    PH_K1D  = 5'd14,
    PH_K2D  = 5'd15,
    PH_KPD  = 5'd16,
    PH_RX1  = 5'd17,
    PH_ACK  = 5'd18,
    PH_RX2  = 5'd19,
    PH_NAK  = 5'd20,
    PH_SP1  = 5'd21,
    PH_SP2  = 5'd22
  } phase_t;

  // Input item kinds.
  localparam logic KIND_TICK    = 1'b0;
  localparam logic KIND_REQUEST = 1'b1;

  // Configuration register indexes.
  localparam logic [1:0] REG_DEVICE_ADDRESS = 2'd0;
  localparam logic [1:0] REG_REGISTER_INDEX = 2'd1;
  localparam logic [1:0] REG_ACK_TIMEOUT    = 2'd2;

  localparam logic [6:0] DEVICE_ADDRESS_RST = 7'd80;
  localparam logic [7:0] REGISTER_INDEX_RST = 8'h08;
  localparam logic [7:0] ACK_TIMEOUT_RST    = 8'd250;

  // Step lengths in microsecond ticks.
  localparam logic [3:0] START_TICKS = 4'd4;
  localparam logic [3:0] TX_BIT_TICKS = 4'd6;
  localparam logic [3:0] RX_BIT_TICKS = 4'd3;
  localparam logic [3:0] ACK_TICKS = 4'd4;
  localparam logic [3:0] STOP_TICKS = 4'd4;
  localparam logic [4:0] BYTE_BITS = 5'd8;

  // Key controller reports one bit per key in the first byte.
  function automatic logic [2:0] decode_key(input logic [7:0] b);
    logic [2:0] k;
    unique case (b)
      8'h20:   k = 3'd1;
      8'h40:   k = 3'd2;
      8'h80:   k = 3'd3;
      8'h10:   k = 3'd4;
      8'h08:   k = 3'd5;
      8'h04:   k = 3'd6;
      default: k = 3'd0;
    endcase
    return k;
  endfunction

  // Phases in which the master lets go of SDA.
  function automatic logic sda_released(input phase_t p);
    return p == PH_K1A || p == PH_K2A || p == PH_KPA ||
           p == PH_K1R || p == PH_K2R || p == PH_KPR ||
           p == PH_K1D || p == PH_K2D || p == PH_KPD ||
           p == PH_RX1 || p == PH_RX2;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/i2ck_req_if.sv -----
`default_nettype none
interface i2ck_req_if;
  logic valid;
  logic ready;
  logic kind;
  logic sda_in;

  modport source (output valid, output kind, output sda_in, input ready);
  modport sink (input valid, input kind, input sda_in, output ready);
endinterface
`default_nettype wire

// ----- rtl/i2ck_rsp_if.sv -----
`default_nettype none
interface i2ck_rsp_if;
  logic       valid;
  logic       ready;
  logic       scl_out;
  logic       sda_out;
  logic       sda_drive;
  logic       busy_res;
  logic       done_res;
  logic [2:0] key_code;
  logic       ack_failed;

  modport source (output valid, output scl_out, output sda_out, output sda_drive,
                  output busy_res, output done_res, output key_code, output ack_failed,
                  input ready);
  modport sink (input valid, input scl_out, input sda_out, input sda_drive,
                input busy_res, input done_res, input key_code, input ack_failed,
                output ready);
endinterface
`default_nettype wire

// ----- rtl/i2ck_touch_key_reader.sv -----
`default_nettype none
// Channel | Dir | Payload                                            | Handshake
// req     | in  | kind, sda_in                                       | valid/ready
// rsp     | out | scl_out, sda_out, sda_drive, busy_res, done_res,   | valid/ready
//         |     | key_code, ack_failed                               |
// APB     | in  | device_address, register_index, ack_timeout        | psel/penable
//
// One item is accepted per clock cycle when the result side keeps up. An item
// lands in the input register; the sequencer then consumes it and its result
// is written to the result register, once that register can take it. While a
// result waits in the result register, an empty input register can still take
// one item; once it holds an item, req stalls until rsp takes the waiting
// result.
// Reset (rst, synchronous, active high) puts the sequencer in idle with both
// bus lines high and restores the configuration defaults.
module i2c_touch_key_reader
  import i2ck_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  i2ck_req_if.sink         req,
  i2ck_rsp_if.source       rsp,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);

  // Configuration registers.
  logic [6:0] device_address;
  logic [7:0] register_index;
  logic [7:0] ack_timeout;

  logic [1:0] reg_sel;
  logic       cfg_write;

  assign pready    = 1'b1;
  assign reg_sel   = paddr[3:2];
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      device_address <= DEVICE_ADDRESS_RST;
      register_index <= REGISTER_INDEX_RST;
      ack_timeout    <= ACK_TIMEOUT_RST;
    end else if (cfg_write) begin
      unique case (reg_sel)
        REG_DEVICE_ADDRESS: device_address <= pwdata[6:0];
        REG_REGISTER_INDEX: register_index <= pwdata[7:0];
        REG_ACK_TIMEOUT:    ack_timeout    <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_DEVICE_ADDRESS: prdata = {25'd0, device_address};
      REG_REGISTER_INDEX: prdata = {24'd0, register_index};
      REG_ACK_TIMEOUT:    prdata = {24'd0, ack_timeout};
      default:            prdata = 32'd0;
    endcase
  end

  // Input register. It empties whenever the result register can take the
  // result, so the sequencer step and the result write happen together.
  logic ir_valid;
  logic ir_kind;
  logic ir_sda;
  logic advance;
  logic step;

  assign advance   = !rsp.valid || rsp.ready;
  assign step      = ir_valid && advance;
  assign req.ready = !ir_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      ir_valid <= 1'b0;
    end else if (req.ready) begin
      ir_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      ir_kind <= req.kind;
      ir_sda  <= req.sda_in;
    end
  end

  // Sequencer state.
  phase_t     phase, phase_next;
  logic [3:0] bit_count, bit_count_next;
  logic [2:0] wait_count, wait_count_next;
  logic [7:0] shift_byte, shift_byte_next;
  logic [7:0] poll_count, poll_count_next;
  logic [2:0] last_key, last_key_next;
  logic       error_flag, error_flag_next;
  logic       scl_level, scl_level_next;
  logic       sda_level, sda_level_next;
  logic       done_next;

  logic [3:0] wait_inc;
  logic [4:0] bit_inc;
  logic [7:0] rx_shift;

  assign wait_inc = {1'b0, wait_count} + 4'd1;
  assign bit_inc  = {1'b0, bit_count} + 5'd1;
  assign rx_shift = {shift_byte[6:0], ir_sda};

  // One sequencer step per item. Entering a new phase always clears the
  // tick and bit counters.
  always_comb begin
    phase_next      = phase;
    bit_count_next  = bit_count;
    wait_count_next = wait_count;
    shift_byte_next = shift_byte;
    poll_count_next = poll_count;
    last_key_next   = last_key;
    error_flag_next = error_flag;
    scl_level_next  = scl_level;
    sda_level_next  = sda_level;
    done_next       = 1'b0;

    if (ir_kind == KIND_REQUEST) begin
      // A request while a transaction runs is dropped.
      if (phase == PH_IDLE) begin
        error_flag_next = 1'b0;
        last_key_next   = 3'd0;
        poll_count_next = 8'd0;
        shift_byte_next = 8'd0;
        phase_next      = PH_S1A;
        wait_count_next = 3'd0;
        bit_count_next  = 4'd0;
      end
    end else begin
      unique case (phase)
        PH_IDLE: begin
          scl_level_next = 1'b1;
          sda_level_next = 1'b1;
        end
        PH_S1A, PH_S1B: begin
          scl_level_next = 1'b1;
          sda_level_next = 1'b1;
          wait_count_next = wait_inc[2:0];
          if (wait_inc >= START_TICKS) begin
            phase_next      = (phase == PH_S1A) ? PH_S2A : PH_S2B;
            wait_count_next = 3'd0;
            bit_count_next  = 4'd0;
          end
        end
        PH_S2A, PH_S2B: begin
          scl_level_next = 1'b1;
          sda_level_next = 1'b0;
          wait_count_next = wait_inc[2:0];
          if (wait_inc >= START_TICKS) begin
            wait_count_next = 3'd0;
            bit_count_next  = 4'd0;
            if (phase == PH_S2A) begin
              phase_next      = PH_TXA;
              shift_byte_next = {device_address, 1'b0};
            end else begin
              phase_next      = PH_TXD;
              shift_byte_next = {device_address, 1'b1};
            end
          end
        end
        PH_TXA, PH_TXR, PH_TXD: begin
          sda_level_next  = shift_byte[7];
          scl_level_next  = (wait_count == 3'd2) || (wait_count == 3'd3);
          wait_count_next = wait_inc[2:0];
          if (wait_inc >= TX_BIT_TICKS) begin
            wait_count_next = 3'd0;
            shift_byte_next = {shift_byte[6:0], 1'b0};
            bit_count_next  = bit_inc[3:0];
            if (bit_inc >= BYTE_BITS) begin
              phase_next     = phase_t'(phase + 5'd1);
              bit_count_next = 4'd0;
            end
          end
        end
        PH_K1A, PH_K1R, PH_K1D: begin
          scl_level_next  = 1'b0;
          sda_level_next  = 1'b1;
          phase_next      = phase_t'(phase + 5'd1);
          wait_count_next = 3'd0;
          bit_count_next  = 4'd0;
        end
        PH_K2A, PH_K2R, PH_K2D: begin
          scl_level_next  = 1'b1;
          sda_level_next  = 1'b1;
          poll_count_next = 8'd0;
          phase_next      = phase_t'(phase + 5'd1);
          wait_count_next = 3'd0;
          bit_count_next  = 4'd0;
        end
        PH_KPA, PH_KPR, PH_KPD: begin
          sda_level_next = 1'b1;
          if (!ir_sda) begin
            // Acknowledge seen: pull SCL low and go on.
            scl_level_next  = 1'b0;
            wait_count_next = 3'd0;
            bit_count_next  = 4'd0;
            if (phase == PH_KPA) begin
              phase_next      = PH_TXR;
              shift_byte_next = register_index;
            end else if (phase == PH_KPR) begin
              phase_next = PH_S1B;
            end else begin
              phase_next      = PH_RX1;
              shift_byte_next = 8'd0;
            end
          end else if (poll_count >= ack_timeout) begin
            // No acknowledge in time: abandon with a stop.
            scl_level_next  = 1'b1;
            error_flag_next = 1'b1;
            phase_next      = PH_SP1;
            wait_count_next = 3'd0;
            bit_count_next  = 4'd0;
          end else begin
            scl_level_next  = 1'b1;
            poll_count_next = poll_count + 8'd1;
          end
        end
        PH_RX1, PH_RX2: begin
          sda_level_next = 1'b1;
          scl_level_next = (wait_count == 3'd2);
          if (wait_count == 3'd2) begin
            shift_byte_next = rx_shift;
          end
          wait_count_next = wait_inc[2:0];
          if (wait_inc >= RX_BIT_TICKS) begin
            wait_count_next = 3'd0;
            bit_count_next  = bit_inc[3:0];
            if (bit_inc >= BYTE_BITS) begin
              bit_count_next = 4'd0;
              if (phase == PH_RX1) begin
                last_key_next = decode_key(shift_byte_next);
                phase_next    = PH_ACK;
              end else begin
                phase_next = PH_NAK;
              end
            end
          end
        end
        PH_ACK, PH_NAK: begin
          sda_level_next  = (phase == PH_NAK);
          scl_level_next  = (wait_count >= 3'd2);
          wait_count_next = wait_inc[2:0];
          if (wait_inc >= ACK_TICKS) begin
            wait_count_next = 3'd0;
            bit_count_next  = 4'd0;
            if (phase == PH_ACK) begin
              phase_next      = PH_RX2;
              shift_byte_next = 8'd0;
            end else begin
              phase_next = PH_SP1;
            end
          end
        end
        PH_SP1: begin
          scl_level_next  = 1'b0;
          sda_level_next  = 1'b0;
          wait_count_next = wait_inc[2:0];
          if (wait_inc >= STOP_TICKS) begin
            phase_next      = PH_SP2;
            wait_count_next = 3'd0;
            bit_count_next  = 4'd0;
          end
        end
        PH_SP2: begin
          scl_level_next  = 1'b1;
          sda_level_next  = 1'b1;
          wait_count_next = wait_inc[2:0];
          if (wait_inc >= STOP_TICKS) begin
            phase_next      = PH_IDLE;
            wait_count_next = 3'd0;
            bit_count_next  = 4'd0;
            done_next       = 1'b1;
          end
        end
        default: begin
          scl_level_next  = 1'b1;
          sda_level_next  = 1'b1;
          phase_next      = PH_IDLE;
          wait_count_next = 3'd0;
          bit_count_next  = 4'd0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_IDLE;
      bit_count  <= 4'd0;
      wait_count <= 3'd0;
      shift_byte <= 8'd0;
      poll_count <= 8'd0;
      last_key   <= 3'd0;
      error_flag <= 1'b0;
      scl_level  <= 1'b1;
      sda_level  <= 1'b1;
    end else if (step) begin
      phase      <= phase_next;
      bit_count  <= bit_count_next;
      wait_count <= wait_count_next;
      shift_byte <= shift_byte_next;
      poll_count <= poll_count_next;
      last_key   <= last_key_next;
      error_flag <= error_flag_next;
      scl_level  <= scl_level_next;
      sda_level  <= sda_level_next;
    end
  end

  // Result register. The outputs reflect the bus levels after the step.
  logic rel_next;

  assign rel_next = sda_released(phase_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (advance) begin
      rsp.valid <= ir_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      rsp.scl_out    <= scl_level_next;
      rsp.sda_out    <= rel_next ? 1'b1 : sda_level_next;
      rsp.sda_drive  <= !rel_next;
      rsp.busy_res   <= (phase_next != PH_IDLE);
      rsp.done_res   <= done_next;
      rsp.key_code   <= last_key_next;
      rsp.ack_failed <= error_flag_next;
    end
  end

  // The sequencer only moves when an item is handed to the result register.
  a_state_holds: assert property (@(posedge clk) disable iff (rst)
    !step |=> $stable(phase) && $stable(shift_byte) && $stable(poll_count))
    else $error("sequencer state changed without an item");

  // Every consumed item produces a result.
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    step |=> rsp.valid)
    else $error("item consumed without a result");

  // Idle leaves the counters cleared.
  a_idle_clear: assert property (@(posedge clk) disable iff (rst)
    phase == PH_IDLE |-> wait_count == 3'd0 && bit_count == 4'd0)
    else $error("counters not cleared in idle");

  // An acknowledge timeout always leads straight into the stop.
  a_error_stop: assert property (@(posedge clk) disable iff (rst)
    $rose(error_flag) |-> phase == PH_SP1)
    else $error("error flag raised outside of a timeout");

  // A finished transaction is reported as no longer busy.
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    step && done_next |=> !rsp.busy_res && phase == PH_IDLE)
    else $error("done reported while still busy");

endmodule
`default_nettype wire
